/* rtl/core/cls_pkg.sv */
package cls_pkg;

  localparam int MAX_FIELDS = 256;
  localparam logic [7:0] FIELD_TOP =
    8'((MAX_FIELDS - 1 < 255) ? (MAX_FIELDS - 1) : 255);
  localparam int MAX_RESULTS = 3;

  typedef enum logic [1:0] {
    MODE_WAIT  = 2'd0,
    MODE_FIELD = 2'd1,
    MODE_QUOTE = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    KIND_BYTE      = 3'd0,
    KIND_END       = 3'd1,
    KIND_DONE      = 3'd2,
    KIND_QUOTE_ERR = 3'd3,
    KIND_EMPTY_ERR = 3'd4
  } kind_t;

  localparam logic [7:0] CH_BACKSLASH = 8'h5c;
  localparam logic [7:0] CH_DQUOTE    = 8'h22;
  localparam logic [7:0] CH_SQUOTE    = 8'h27;
  localparam logic [7:0] CH_SPACE     = 8'h20;

  typedef struct packed {
    logic [7:0] ch;
    logic       byte_valid;
    logic       end_of_line;
  } cls_in_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] out_byte;
    logic [7:0] field_index;
    logic       last;
  } cls_out_t;

  typedef struct packed {
    cls_out_t [MAX_RESULTS-1:0] res;
    logic [1:0]                 cnt;
  } cls_bundle_t;

  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h6e:   r = 8'd10;
      8'h72:   r = 8'd13;
      8'h74:   r = 8'd9;
      8'h61:   r = 8'd7;
      8'h62:   r = 8'd8;
      8'h76:   r = 8'd11;
      8'h66:   r = 8'd12;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= 8'd9 && c <= 8'd13);
  endfunction

endpackage

/* rtl/core/cls_parser.sv */
module cls_parser
  import cls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  cls_in_t     item,
  output cls_bundle_t bundle
);

  mode_t      mode_r, mode_nxt;
  logic       esc_r, esc_nxt;
  logic       qdbl_r, qdbl_nxt;
  logic       fne_r, fne_nxt;
  logic       path_r, path_nxt;
  logic [7:0] fcnt_r, fcnt_nxt;

  logic       put_en;
  logic [7:0] put_val;
  logic       blank_end;
  logic       is_quote;
  logic [1:0] n;

  always_comb begin
    put_en    = 1'b0;
    put_val   = item.ch;
    blank_end = 1'b0;
    mode_nxt  = mode_r;
    esc_nxt   = esc_r;
    qdbl_nxt  = qdbl_r;
    fne_nxt   = fne_r;
    path_nxt  = path_r;
    fcnt_nxt  = fcnt_r;
    n         = 2'd0;
    bundle    = '0;
    is_quote  = (item.ch == CH_DQUOTE) || (item.ch == CH_SQUOTE);

    if (item.byte_valid) begin
      if (esc_r) begin
        put_en  = 1'b1;
        put_val = unescape(item.ch);
        esc_nxt = 1'b0;
        if (mode_r != MODE_QUOTE) mode_nxt = MODE_FIELD;
      end else if (item.ch == CH_BACKSLASH) begin
        esc_nxt = 1'b1;
      end else if (mode_r == MODE_QUOTE) begin
        if (item.ch == (qdbl_r ? CH_DQUOTE : CH_SQUOTE)) mode_nxt = MODE_FIELD;
        else put_en = 1'b1;
      end else if (is_quote) begin
        mode_nxt = MODE_QUOTE;
        qdbl_nxt = (item.ch == CH_DQUOTE);
      end else if (is_blank(item.ch)) begin
        if (mode_r == MODE_FIELD) begin
          blank_end = 1'b1;
          mode_nxt  = MODE_WAIT;
        end
      end else begin
        put_en   = 1'b1;
        mode_nxt = MODE_FIELD;
      end
    end

    if (put_en) begin
      bundle.res[n].kind        = KIND_BYTE;
      bundle.res[n].out_byte    = put_val;
      bundle.res[n].field_index = fcnt_nxt;
      n       = n + 2'd1;
      fne_nxt = 1'b1;
    end

    if (blank_end) begin
      if (fne_nxt || path_nxt) begin
        bundle.res[n].kind        = KIND_END;
        bundle.res[n].field_index = fcnt_nxt;
        n = n + 2'd1;
        if (fne_nxt) path_nxt = 1'b1;
        if (fcnt_nxt < FIELD_TOP) fcnt_nxt = fcnt_nxt + 8'd1;
      end
      fne_nxt = 1'b0;
    end

    if (item.end_of_line) begin
      if (mode_nxt == MODE_QUOTE) begin
        bundle.res[n].kind = KIND_QUOTE_ERR;
        n = n + 2'd1;
      end else begin
        if (mode_nxt == MODE_FIELD) begin
          if (fne_nxt || path_nxt) begin
            bundle.res[n].kind        = KIND_END;
            bundle.res[n].field_index = fcnt_nxt;
            n = n + 2'd1;
            if (fne_nxt) path_nxt = 1'b1;
          end
        end
        bundle.res[n].kind = path_nxt ? KIND_DONE : KIND_EMPTY_ERR;
        n = n + 2'd1;
      end
      mode_nxt = MODE_WAIT;
      esc_nxt  = 1'b0;
      qdbl_nxt = 1'b0;
      fne_nxt  = 1'b0;
      path_nxt = 1'b0;
      fcnt_nxt = 8'd0;
    end

    for (int i = 0; i < MAX_RESULTS; i++) begin
      bundle.res[i].last = (n != 2'd0) && (2'(i) == n - 2'd1);
    end
    bundle.cnt = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_WAIT;
      esc_r  <= 1'b0;
      qdbl_r <= 1'b0;
      fne_r  <= 1'b0;
      path_r <= 1'b0;
      fcnt_r <= 8'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      esc_r  <= esc_nxt;
      qdbl_r <= qdbl_nxt;
      fne_r  <= fne_nxt;
      path_r <= path_nxt;
      fcnt_r <= fcnt_nxt;
    end
  end

endmodule

/* rtl/core/cls_out_queue.sv */
module cls_out_queue
  import cls_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        accept,
  input  cls_bundle_t bundle,
  output logic        can_accept,
  output logic        out_valid,
  input  logic        out_ready,
  output cls_out_t    out_data
);

  cls_out_t   out_r, out_nxt;
  logic       vld_r, vld_nxt;
  cls_out_t   slot0_r, slot0_nxt;
  cls_out_t   slot1_r, slot1_nxt;
  logic [1:0] bcnt_r, bcnt_nxt;
  logic       out_free;

  assign out_free   = !vld_r || out_ready;
  assign can_accept = (bcnt_r == 2'd0) && out_free;
  assign out_valid  = vld_r;
  assign out_data   = out_r;

  always_comb begin
    out_nxt   = out_r;
    vld_nxt   = vld_r;
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    bcnt_nxt  = bcnt_r;
    if (accept) begin
      out_nxt   = bundle.res[0];
      vld_nxt   = (bundle.cnt != 2'd0);
      slot0_nxt = bundle.res[1];
      slot1_nxt = bundle.res[2];
      bcnt_nxt  = (bundle.cnt != 2'd0) ? bundle.cnt - 2'd1 : 2'd0;
    end else if (bcnt_r != 2'd0 && out_free) begin
      out_nxt   = slot0_r;
      vld_nxt   = 1'b1;
      slot0_nxt = slot1_r;
      bcnt_nxt  = bcnt_r - 2'd1;
    end else if (vld_r && out_ready) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= 1'b0;
      bcnt_r <= 2'd0;
    end else begin
      vld_r  <= vld_nxt;
      bcnt_r <= bcnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r   <= out_nxt;
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

endmodule

/* rtl/core/command_line_word_splitter_top.sv */
// Shell style word splitter: send a command line one byte per request (with
// end_of_line on the last request, optionally as an end-only request) and
// receive decoded field bytes, field ends and one line status per line. An
// input request that produces at most one result is taken every cycle unless
// the output stalls; one with more (up to three) holds the input until its
// results have left through the single output register, one per cycle
// while out_ready is high. Parser state resets after every end of line.
module command_line_word_splitter_top
  import cls_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  cls_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output cls_out_t out_data
);

  cls_bundle_t bundle;
  logic        accept;

  assign accept = in_valid && in_ready;

  cls_parser u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (accept),
    .item   (in_data),
    .bundle (bundle)
  );

  cls_out_queue u_out_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .bundle     (bundle),
    .can_accept (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
